// ----- sv/urpe_pkg.sv -----
`default_nettype none
package urpe_pkg;
  localparam int unsigned LogFrac = 16;
  localparam int unsigned DbPerLog2Q16 = 197283;
  localparam int unsigned RegRate = 0;
  localparam int unsigned RegPrf = 1;
  localparam int unsigned CfgIdxW = 1;

  typedef struct packed {
    logic [15:0] cir;
    logic [33:0] sumsq;
    logic [11:0] n;
    logic        prf;
    logic        zero;
  } urpe_item_t;
endpackage
`default_nettype wire

// ----- sv/uwb_rx_power_estimator.sv -----
`default_nettype none
// uwb receive power estimator
// input channel: push/full; a transaction carries one frame's diagnostics
// (cir growth, three first-path amplitudes, preamble and non-saturated counts)
// result channel: empty/pop; total and first-path power in dB with
// DB_FRAC_BITS fraction bits, and valid_res_o low when any term was zero
// config channel: cfg_valid/cfg_ready, index 0 data rate 110k, index 1 prf 64m;
// cfg_ready is always high, write only while idle
// from push to result on empty an item passes 2 front stages, a 2-entry
// queue and 3 back stages; one item per cycle sustained while pop is high
// reset: all stages empty, rate 110k off, prf 64m on
// when pop stays low the result holds, stages fill, queue fills, then full
// rises; nothing is dropped
module uwb_rx_power_estimator
  import urpe_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = 8,
  parameter int unsigned DB_FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] cir_growth_i,
  input  wire logic [15:0] first_amp_one_i,
  input  wire logic [15:0] first_amp_two_i,
  input  wire logic [15:0] first_amp_three_i,
  input  wire logic [11:0] preamble_count_i,
  input  wire logic [11:0] preamble_nonsat_i,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [16:0] total_power_o,
  output logic signed [16:0] path_power_o,
  output logic             valid_res_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic        cfg_data_i
);
  logic rate_q, prf_q;
  logic f_vld, f_rdy, b_vld, b_rdy;
  urpe_item_t f_item, b_item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 1'b0;
      prf_q <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index_i == CfgIdxW'(RegRate)) rate_q <= cfg_data_i;
      if (cfg_index_i == CfgIdxW'(RegPrf)) prf_q <= cfg_data_i;
    end
  end

  urpe_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .cir_growth_i, .first_amp_one_i, .first_amp_two_i, .first_amp_three_i,
    .preamble_count_i, .preamble_nonsat_i,
    .rate_is_110k_i(rate_q), .prf_is_64m_i(prf_q),
    .item_valid_o(f_vld), .item_ready_i(f_rdy), .item_o(f_item)
  );

  urpe_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_vld), .wr_ready_o(f_rdy), .wr_data_i(f_item),
    .rd_valid_o(b_vld), .rd_ready_i(b_rdy), .rd_data_o(b_item)
  );

  urpe_back #(.LOG_TABLE_BITS(LOG_TABLE_BITS), .DB_FRAC_BITS(DB_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i(b_vld), .item_ready_o(b_rdy), .item_i(b_item),
    .empty, .pop, .total_power_o, .path_power_o, .valid_res_o
  );
endmodule
`default_nettype wire

// ----- sv/urpe_front.sv -----
`default_nettype none
module urpe_front
  import urpe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] cir_growth_i,
  input  wire logic [15:0] first_amp_one_i,
  input  wire logic [15:0] first_amp_two_i,
  input  wire logic [15:0] first_amp_three_i,
  input  wire logic [11:0] preamble_count_i,
  input  wire logic [11:0] preamble_nonsat_i,
  input  wire logic        rate_is_110k_i,
  input  wire logic        prf_is_64m_i,
  output logic             item_valid_o,
  input  wire logic        item_ready_i,
  output urpe_item_t       item_o
);
  logic       s1_vld_q, s1_vld_d;
  logic [31:0] sq1_q, sq2_q, sq3_q;
  logic [15:0] cir_q;
  logic [11:0] n_q;
  logic       prf_q;
  logic [11:0] sfd, n_d;
  logic       s2_vld_q;
  urpe_item_t s2_q;
  logic       s1_go, s2_ld;
  logic [33:0] sum;

  assign sfd = rate_is_110k_i ? 12'd64 : 12'd8;
  always_comb begin
    n_d = preamble_count_i;
    if (preamble_count_i == preamble_nonsat_i) begin
      n_d = (preamble_count_i >= sfd) ? preamble_count_i - sfd : sfd - preamble_count_i;
    end
  end
  assign s2_ld = !s2_vld_q || item_ready_i;
  assign s1_go = !s1_vld_q || s2_ld;
  assign full = !s1_go;
  assign s1_vld_d = s1_go ? push : s1_vld_q;
  assign sum = {2'b0, sq1_q} + {2'b0, sq2_q} + {2'b0, sq3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (s2_ld) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && push) begin
      sq1_q <= first_amp_one_i * first_amp_one_i;
      sq2_q <= first_amp_two_i * first_amp_two_i;
      sq3_q <= first_amp_three_i * first_amp_three_i;
      cir_q <= cir_growth_i;
      n_q   <= n_d;
      prf_q <= prf_is_64m_i;
    end
    if (s2_ld && s1_vld_q) begin
      s2_q.cir   <= cir_q;
      s2_q.sumsq <= sum;
      s2_q.n     <= n_q;
      s2_q.prf   <= prf_q;
      s2_q.zero  <= (cir_q == 16'd0) || (sum == 34'd0) || (n_q == 12'd0);
    end
  end
  assign item_valid_o = s2_vld_q;
  assign item_o = s2_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !item_ready_i |=> s2_vld_q && $stable(s2_q))
    else $error("front item lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> s1_vld_q)
    else $error("accepted transaction not captured");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_go |=> s1_vld_q && $stable(n_q))
    else $error("stage one changed while held");
endmodule
`default_nettype wire

// ----- sv/urpe_queue.sv -----
`default_nettype none
module urpe_queue
  import urpe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  urpe_item_t wr_data_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output urpe_item_t rd_data_o
);
  urpe_item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q == rp_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
    else $error("queue pointers inconsistent");
endmodule
`default_nettype wire

// ----- sv/urpe_back.sv -----
`default_nettype none
module urpe_back
  import urpe_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = 8,
  parameter int unsigned DB_FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  output logic             item_ready_o,
  input  urpe_item_t       item_i,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [16:0] total_power_o,
  output logic signed [16:0] path_power_o,
  output logic             valid_res_o
);
  localparam int unsigned Shift = 2 * LogFrac - DB_FRAC_BITS;
  localparam longint CorrHi = ((64'sd12174 <<< DB_FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam longint CorrLo = ((64'sd11377 <<< DB_FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam int unsigned Entries = 1 << LOG_TABLE_BITS;

  function automatic logic [15:0] frac_rom(input int unsigned m);
    logic [63:0] y;
    logic [15:0] f;
    y = (64'(Entries) + 64'(m)) << (30 - LOG_TABLE_BITS);
    f = '0;
    for (int i = 0; i < LogFrac; i++) begin
      y = (y * y) >> 30;
      f = {f[14:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        f[0] = 1'b1;
        y = y >> 1;
      end
    end
    return f;
  endfunction

  logic [15:0] rom [Entries];
  for (genvar g = 0; g < Entries; g++) begin : g_rom
    assign rom[g] = frac_rom(g);
  end

  function automatic logic [5:0] lead(input logic [33:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 34; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [LOG_TABLE_BITS-1:0] mant(input logic [33:0] x,
                                                  input logic [5:0] p);
    logic [33+LOG_TABLE_BITS:0] w;
    w = {x, {LOG_TABLE_BITS{1'b0}}} >> p;
    return w[LOG_TABLE_BITS-1:0];
  endfunction

  // stage a: log2 of the three terms
  logic        a_vld_q, b_vld_q, c_vld_q;
  logic        a_go, b_go, c_go;
  logic signed [24:0] lc_q, ls_q, ln_q;
  logic        a_zero_q, a_prf_q, b_zero_q, b_prf_q;
  logic [5:0]  pc, ps, pn;
  logic signed [25:0] lvt_d, lvp_d;
  logic signed [25:0] lvt_q, lvp_q;
  logic signed [51:0] pt_q, pp_q;
  logic signed [16:0] ot_d, op_d;

  assign pc = lead({18'd0, item_i.cir});
  assign ps = lead(item_i.sumsq);
  assign pn = lead({22'd0, item_i.n});

  assign c_go = !c_vld_q || pop;
  assign b_go = !b_vld_q || c_go;
  assign a_go = !a_vld_q || b_go;
  assign item_ready_o = a_go;
  assign empty = !c_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_go) a_vld_q <= item_valid_i;
      if (b_go) b_vld_q <= a_vld_q;
      if (c_go) c_vld_q <= b_vld_q;
    end
  end

  assign lvt_d = 26'(lc_q) + 26'(17 << LogFrac) - 26'(ln_q) - 26'(ln_q);
  assign lvp_d = 26'(ls_q) - 26'(ln_q) - 26'(ln_q);

  function automatic logic signed [16:0] to_db(input logic signed [51:0] prod,
                                               input logic prf);
    logic [51:0] mag, r;
    logic signed [53:0] db;
    mag = prod[51] ? 52'(-prod) : prod;
    r = (mag + (52'd1 << (Shift - 1))) >> Shift;
    db = prod[51] ? -$signed({2'b0, r}) : $signed({2'b0, r});
    db = db - (prf ? 54'(CorrHi) : 54'(CorrLo));
    if (db > 54'sd65535) db = 54'sd65535;
    if (db < -54'sd65536) db = -54'sd65536;
    return db[16:0];
  endfunction

  assign ot_d = b_zero_q ? '0 : to_db(pt_q, b_prf_q);
  assign op_d = b_zero_q ? '0 : to_db(pp_q, b_prf_q);

  always_ff @(posedge clk_i) begin
    if (a_go && item_valid_i) begin
      lc_q <= $signed({1'b0, pc, 18'd0} >> 2) + $signed({9'd0, rom[mant({18'd0, item_i.cir}, pc)]});
      ls_q <= $signed({1'b0, ps, 18'd0} >> 2) + $signed({9'd0, rom[mant(item_i.sumsq, ps)]});
      ln_q <= $signed({1'b0, pn, 18'd0} >> 2) + $signed({9'd0, rom[mant({22'd0, item_i.n}, pn)]});
      a_zero_q <= item_i.zero;
      a_prf_q <= item_i.prf;
    end
    if (b_go && a_vld_q) begin
      pt_q <= 52'(lvt_d) * $signed(52'(DbPerLog2Q16));
      pp_q <= 52'(lvp_d) * $signed(52'(DbPerLog2Q16));
      b_zero_q <= a_zero_q;
      b_prf_q <= a_prf_q;
    end
    if (c_go && b_vld_q) begin
      total_power_o <= ot_d;
      path_power_o <= op_d;
      valid_res_o <= !b_zero_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && !pop |=> c_vld_q && $stable(total_power_o))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && !valid_res_o |-> total_power_o == 17'sd0 && path_power_o == 17'sd0)
    else $error("invalid result not zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q && !c_go |=> b_vld_q)
    else $error("stage b dropped");
endmodule
`default_nettype wire

// ----- sim/uwb_rx_power_estimator_tb.sv -----
`timescale 1ns / 1ps
module uwb_rx_power_estimator_tb;
  import urpe_pkg::*;

  localparam int TableBits = 8;
  localparam int FracBits = 8;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [16:0] total;
    logic signed [16:0] path;
    logic               ok;
  } power_est_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [15:0] cir_growth_i = '0;
  logic [15:0] first_amp_one_i = '0;
  logic [15:0] first_amp_two_i = '0;
  logic [15:0] first_amp_three_i = '0;
  logic [11:0] preamble_count_i = '0;
  logic [11:0] preamble_nonsat_i = '0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic cfg_data_i = 1'b0;
  logic full, empty, cfg_ready, valid_res_o;
  logic signed [16:0] total_power_o, path_power_o;

  logic rate_110k = 1'b0;
  logic prf_64m = 1'b1;
  power_est_t expected_powers[$];
  int errors = 0;
  int cycles = 0;
  bit push_idle_on = 1'b1;
  bit pop_idle_on = 1'b1;
  bit pop_hold = 1'b0;

  uwb_rx_power_estimator dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint log_table(int m);
    longint unsigned y;
    longint f;
    y = (longint'(1 << TableBits) + m) << (30 - TableBits);
    f = 0;
    for (int i = 0; i < LogFrac; i++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= (64'd1 << 31)) begin
        f = f | 1;
        y = y >> 1;
      end
    end
    return f;
  endfunction

  function automatic longint log2_fixed(longint unsigned x);
    int p;
    longint unsigned m;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p >= TableBits) m = (x >> (p - TableBits)) & ((1 << TableBits) - 1);
    else m = (x << (TableBits - p)) & ((1 << TableBits) - 1);
    return longint'(p) * (64'sd1 << LogFrac) + log_table(int'(m));
  endfunction

  function automatic logic signed [16:0] level_db(longint level, longint corr);
    longint prod, db;
    longint unsigned mag, r;
    int sh;
    sh = 2 * LogFrac - FracBits;
    prod = level * longint'(DbPerLog2Q16);
    mag = prod < 0 ? -prod : prod;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    db = prod < 0 ? -longint'(r) : longint'(r);
    db = db - corr;
    if (db > 65535) db = 65535;
    if (db < -65536) db = -65536;
    return db[16:0];
  endfunction

  function automatic power_est_t estimate_power(logic [15:0] cir, logic [15:0] a1,
      logic [15:0] a2, logic [15:0] a3, logic [11:0] cnt, logic [11:0] nonsat);
    power_est_t e;
    longint unsigned sumsq;
    int n, sfd;
    longint corr, ln2;
    sumsq = longint'(a1) * a1 + longint'(a2) * a2 + longint'(a3) * a3;
    n = cnt;
    if (cnt == nonsat) begin
      sfd = rate_110k ? 64 : 8;
      n = cnt >= sfd ? cnt - sfd : sfd - cnt;
    end
    if (cir == 0 || sumsq == 0 || n == 0) begin
      e.total = '0;
      e.path = '0;
      e.ok = 1'b0;
      return e;
    end
    corr = ((longint'(prf_64m ? 12174 : 11377) << FracBits) + 50) / 100;
    ln2 = 2 * log2_fixed(n);
    e.total = level_db(log2_fixed(cir) + (64'sd17 << LogFrac) - ln2, corr);
    e.path = level_db(log2_fixed(sumsq) - ln2, corr);
    e.ok = 1'b1;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side: check popped results; random pop, or steady pop when idle is off, with optional hold-off
  always @(posedge clk_i) begin
    power_est_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_powers.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = expected_powers.pop_front();
        if (total_power_o !== e.total) report_mismatch("total_power", total_power_o, e.total);
        if (path_power_o !== e.path) report_mismatch("path_power", path_power_o, e.path);
        if (valid_res_o !== e.ok) report_mismatch("valid_res", valid_res_o, e.ok);
      end
    end
    if (pop_hold) begin
      pop <= 1'b0;
    end else begin
      pop <= pop_idle_on ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  task automatic send_frame(logic [15:0] cir, logic [15:0] a1, logic [15:0] a2,
      logic [15:0] a3, logic [11:0] cnt, logic [11:0] nonsat);
    while (push_idle_on && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cir_growth_i <= cir;
    first_amp_one_i <= a1;
    first_amp_two_i <= a2;
    first_amp_three_i <= a3;
    preamble_count_i <= cnt;
    preamble_nonsat_i <= nonsat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_powers.push_back(estimate_power(cir, a1, a2, a3, cnt, nonsat));
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == RegRate) rate_110k = val;
    else prf_64m = val;
  endtask

  task automatic set_config(logic rate, logic prf);
    drain();
    write_reg(RegRate, rate);
    write_reg(RegPrf, prf);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_frame;
    logic [11:0] cnt;
    cnt = 12'(($urandom_range(3) == 0) ? $urandom_range(80) : $urandom_range(4095));
    send_frame($urandom_range(15) == 0 ? 16'($urandom_range(3)) : 16'($urandom),
               16'($urandom), 16'($urandom),
               $urandom_range(7) == 0 ? 16'h0 : 16'($urandom), cnt,
               $urandom_range(1) ? cnt : 12'($urandom));
  endtask

  task automatic test_directed;
    send_frame(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'h000);
    send_frame(16'h0001, 16'h0001, 16'h0000, 16'h0000, 12'h001, 12'h000);
    send_frame(16'h0000, 16'h1234, 16'h0001, 16'h0002, 12'd100, 12'd5);
    send_frame(16'h4000, 16'h0000, 16'h0000, 16'h0000, 12'd100, 12'd5);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd0, 12'd5);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd8, 12'd8);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd3, 12'd3);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd0, 12'd0);
    send_frame(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'd9, 12'd9);
    send_frame(16'h0001, 16'h0000, 16'h0000, 16'h0001, 12'hfff, 12'hfff);
    send_frame(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 12'haaa, 12'h555);
    send_frame(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 12'h555, 12'haaa);
    set_config(1'b1, 1'b0);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd64, 12'd64);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd10, 12'd10);
    send_frame(16'h4000, 16'h0100, 16'h0200, 16'h0300, 12'd65, 12'd65);
    send_frame(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'hfff);
    send_frame(16'h0001, 16'h0001, 16'h0000, 16'h0000, 12'd1, 12'd2);
  endtask

  task automatic test_random;
    for (int k = 0; k < 4; k++) begin
      set_config(k[0], k[1]);
      for (int i = 0; i < 80; i++) send_random_frame();
    end
  endtask

  task automatic test_no_idle;
    push_idle_on = 1'b0;
    pop_idle_on = 1'b0;
    for (int i = 0; i < 60; i++) send_random_frame();
    push_idle_on = 1'b1;
    pop_idle_on = 1'b1;
  endtask

  task automatic test_backpressure;
    fork
      begin
        pop_hold <= 1'b1;
        repeat (60) @(posedge clk_i);
        pop_hold <= 1'b0;
      end
    join_none
    push_idle_on = 1'b0;
    for (int i = 0; i < 30; i++) send_random_frame();
    push_idle_on = 1'b1;
    drain();
    for (int i = 0; i < 20; i++) send_random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_no_idle();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
